// File: hw/rtl/ufr_pkg.sv
// Shared types, register indexes and helpers for the UART frame receiver.
package ufr_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 8;
  localparam int unsigned WordWidth     = 8;
  localparam int unsigned FrameWidth    = 12;
  localparam int unsigned CountWidth    = 4;

  localparam logic [CfgIndexWidth-1:0] CFG_WORD_LEN_CODE = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_PARITY_EN     = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_EVEN_PARITY   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_STICK_PARITY  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_TWO_STOP_BITS = 3'd4;

  typedef struct packed {
    logic [1:0] word_length_code;
    logic       parity_enable;
    logic       even_parity;
    logic       stick_parity;
    logic       two_stop_bits;
  } cfg_t;

  // start + (5 + code) data + parity + (1 + two_stop) stop bits
  function automatic logic [CountWidth-1:0] frame_len(input cfg_t cfg);
    frame_len = 4'd7 + {2'b00, cfg.word_length_code} + {3'b000, cfg.parity_enable}
              + {3'b000, cfg.two_stop_bits};
  endfunction

endpackage

// File: hw/rtl/uart_frame_receiver.sv
// UART frame receiver top level: bit shifter, frame end detect and output register.
// The word of a good frame appears on the output in the cycle after its last bit is accepted.
// Throughput: one line bit per cycle while the input is not stalled; bit state and
// frame check are combinational between the bit registers and the output register.
// Input stalls only while a finished word is held and the output side stalls.
// Reset: asynchronous, active low; idle, counters and shifter cleared, registers to
// eight data bits, no parity, one stop bit.
module uart_frame_receiver import ufr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     rx_bit_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [WordWidth-1:0]     received_word_o
);

  cfg_t                  cfg_q;
  logic                  in_frame_q, in_frame_d;
  logic [CountWidth-1:0] bit_count_q, bit_count_d;
  logic [FrameWidth-1:0] frame_shift_q, frame_shift_d;
  logic                  out_valid_q, out_valid_d;
  logic [WordWidth-1:0]  word_q;

  logic                  in_accept;
  logic                  take_bit;
  logic [CountWidth-1:0] count_next;
  logic [FrameWidth-1:0] shift_next;
  logic                  frame_end;
  logic                  frame_good;
  logic [WordWidth-1:0]  frame_word;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{word_length_code: 2'd3, parity_enable: 1'b0, even_parity: 1'b0,
                 stick_parity: 1'b0, two_stop_bits: 1'b0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WORD_LEN_CODE: cfg_q.word_length_code <= cfg_data_i[1:0];
        CFG_PARITY_EN:     cfg_q.parity_enable    <= cfg_data_i[0];
        CFG_EVEN_PARITY:   cfg_q.even_parity      <= cfg_data_i[0];
        CFG_STICK_PARITY:  cfg_q.stick_parity     <= cfg_data_i[0];
        CFG_TWO_STOP_BITS: cfg_q.two_stop_bits    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign take_bit   = in_frame_q || !rx_bit_i;
  assign count_next = bit_count_q + 4'd1;
  assign shift_next = {frame_shift_q[FrameWidth-2:0], rx_bit_i};
  assign frame_end  = take_bit && (count_next >= frame_len(cfg_q));

  ufr_frame_check u_check (
    .cfg_i   (cfg_q),
    .frame_i (shift_next),
    .good_o  (frame_good),
    .word_o  (frame_word)
  );

  always_comb begin
    in_frame_d    = in_frame_q;
    bit_count_d   = bit_count_q;
    frame_shift_d = frame_shift_q;
    if (in_accept && take_bit) begin
      if (frame_end) begin
        in_frame_d    = 1'b0;
        bit_count_d   = '0;
        frame_shift_d = '0;
      end else begin
        in_frame_d    = 1'b1;
        bit_count_d   = count_next;
        frame_shift_d = shift_next;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = frame_end && frame_good;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      bit_count_q   <= '0;
      frame_shift_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      in_frame_q    <= in_frame_d;
      bit_count_q   <= bit_count_d;
      frame_shift_q <= frame_shift_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && frame_end && frame_good) begin
      word_q <= frame_word;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign received_word_o = word_q;

endmodule

// File: hw/rtl/ufr_frame_check.sv
// Frame checker: extracts the data word and validates start, parity and stop bits.
module ufr_frame_check import ufr_pkg::*; (
  input  cfg_t                  cfg_i,
  input  logic [FrameWidth-1:0] frame_i,
  output logic                  good_o,
  output logic [WordWidth-1:0]  word_o
);

  logic [CountWidth-1:0] len;
  logic [CountWidth-1:0] wlen;
  logic [1:0]            stops;
  logic [1:0]            data_base;
  logic [FrameWidth-1:0] data_bits;
  logic                  start_ok;
  logic                  stop_ok;
  logic                  parity_ok;
  logic                  want_parity;

  assign len       = frame_len(cfg_i);
  assign wlen      = 4'd5 + {2'b00, cfg_i.word_length_code};
  assign stops     = 2'd1 + {1'b0, cfg_i.two_stop_bits};
  assign data_base = stops + {1'b0, cfg_i.parity_enable};
  assign data_bits = frame_i >> data_base;

  // first bit on the line sits highest in the frame; reverse into bit 0 upward
  always_comb begin : word_extract
    logic [CountWidth-1:0] idx;
    word_o = '0;
    idx    = '0;
    for (int i = 0; i < WordWidth; i++) begin
      idx = wlen - CountWidth'(i + 1);
      if (CountWidth'(i) < wlen) begin
        word_o[i] = data_bits[idx];
      end
    end
  end

  assign start_ok = ~frame_i[len - 4'd1];
  assign stop_ok  = cfg_i.two_stop_bits ? (frame_i[1:0] == 2'b11) : frame_i[0];

  always_comb begin
    if (cfg_i.stick_parity) begin
      want_parity = ~cfg_i.even_parity;
    end else if (cfg_i.even_parity) begin
      want_parity = ^word_o;
    end else begin
      want_parity = ~(^word_o);
    end
  end

  assign parity_ok = ~cfg_i.parity_enable || (frame_i[{2'b00, stops}] == want_parity);
  assign good_o    = start_ok && stop_ok && parity_ok;

endmodule

// File: hw/rtl/ufr_checker.sv
// Port-level checker for the UART frame receiver, bound to the top level.
module ufr_port_checker import ufr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [WordWidth-1:0] received_word_o
);

  // a held word must not change while the output side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(received_word_o))
    else $error("word changed or dropped under output stall");

  // input only stalls when a word is held and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output word");

  // a new word only follows an accepted line bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("word appeared without an accepted bit");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output register empty");

endmodule

bind uart_frame_receiver ufr_port_checker u_ufr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .received_word_o (received_word_o)
);
